/* hdl/triple_key_table_wildcard_delete_top_defines.svh */
// Assertion macros used by the triple-key table sequencer.
`ifndef TRIPLE_KEY_TABLE_WILDCARD_DELETE_TOP_DEFINES_SVH
`define TRIPLE_KEY_TABLE_WILDCARD_DELETE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define TKTWD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define TKTWD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define TKTWD_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define TKTWD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

/* hdl/tktwd_pkg.sv */
// Types and constants of the triple-key table.
package tktwd_pkg;

  localparam int KEY_W       = 16;
  localparam int TRIPLE_W    = 3 * KEY_W;
  localparam int CNT_OUT_W   = 11;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_LOOKUP = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_CLEAR,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [TRIPLE_W-1:0] keys;
    logic                valid;
  } entry_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } ring_ctl_t;

endpackage

/* hdl/tktwd_cell.sv */
// One slot of the table ring: holds a triple and its valid bit.
module tktwd_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  tktwd_pkg::ring_ctl_t ctl,
  input  tktwd_pkg::entry_t    prev,
  output tktwd_pkg::entry_t    cur
);
  import tktwd_pkg::*;

  logic [TRIPLE_W-1:0] keys;
  logic                valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctl.clear) begin
      valid <= 1'b0;
    end else if (ctl.shift) begin
      valid <= prev.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      keys <= prev.keys;
    end
  end

  assign cur.keys  = keys;
  assign cur.valid = valid;

endmodule

/* hdl/tktwd_ctrl.sv */
// Request sequencer: walks the ring one slot a cycle and builds the result.
`include "triple_key_table_wildcard_delete_top_defines.svh"
module tktwd_ctrl #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [tktwd_pkg::IN_TDATA_W-1:0]    s_tdata,
  input  logic [1:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [tktwd_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  tktwd_pkg::entry_t                   tail,
  output tktwd_pkg::entry_t                   head,
  output tktwd_pkg::ring_ctl_t                ctl
);
  import tktwd_pkg::*;

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  state_t              state, state_next;
  kind_t               kind;
  logic [TRIPLE_W-1:0] want;
  logic [2:0]          any_key;
  logic [CNT_W-1:0]    step;
  logic [CNT_W-1:0]    removed;
  logic [CNT_W-1:0]    count;
  logic                dup, have_free, found;

  logic    accept, last_step, hit_exact, hit_masked, load_out;
  logic    dup_seen, free_seen;
  status_t status;

  assign accept    = s_tvalid && s_tready;
  assign last_step = (step == CNT_W'(TABLE_DEPTH - 1));
  assign hit_exact = tail.valid && (tail.keys == want);
  assign hit_masked = tail.valid
      && (any_key[0] || tail.keys[3*KEY_W-1:2*KEY_W] == want[3*KEY_W-1:2*KEY_W])
      && (any_key[1] || tail.keys[2*KEY_W-1:KEY_W] == want[2*KEY_W-1:KEY_W])
      && (any_key[2] || tail.keys[KEY_W-1:0] == want[KEY_W-1:0]);
  assign dup_seen  = dup || hit_exact;
  assign free_seen = have_free || !tail.valid;
  assign load_out  = (state == S_DONE) && (!m_tvalid || m_tready);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = (kind_t'(s_tuser) == KIND_CLEAR) ? S_CLEAR : S_SCAN;
        end
      end
      S_SCAN: begin
        if (last_step) begin
          state_next = (kind == KIND_INSERT && !dup_seen && free_seen) ? S_PLACE : S_DONE;
        end
      end
      S_PLACE: begin
        if (!tail.valid) begin
          state_next = S_DONE;
        end
      end
      S_CLEAR: state_next = S_DONE;
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = 1'b0;
    ctl.shift = 1'b0;
    ctl.clear = 1'b0;
    head      = tail;
    case (state)
      S_IDLE: s_tready = 1'b1;
      S_SCAN: begin
        ctl.shift = 1'b1;
        // drop matching entries as they pass the head
        if (kind == KIND_DELETE && hit_masked) begin
          head.valid = 1'b0;
        end
      end
      S_PLACE: begin
        ctl.shift = 1'b1;
        if (!tail.valid) begin
          head.keys  = want;
          head.valid = 1'b1;
        end
      end
      S_CLEAR: ctl.clear = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    status = ST_DONE;
    if (kind == KIND_INSERT) begin
      if (dup) begin
        status = ST_DUP;
      end else if (!have_free) begin
        status = ST_FULL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SCAN && kind == KIND_DELETE && hit_masked) begin
        count <= count - 1'b1;
      end else if (state == S_PLACE && !tail.valid) begin
        count <= count + 1'b1;
      end else if (state == S_CLEAR) begin
        count <= '0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind      <= kind_t'(s_tuser);
      want      <= {s_tdata[KEY_W-1:0], s_tdata[2*KEY_W-1:KEY_W],
                    s_tdata[3*KEY_W-1:2*KEY_W]};
      any_key   <= s_tdata[3*KEY_W+2:3*KEY_W];
      step      <= '0;
      removed   <= '0;
      dup       <= 1'b0;
      have_free <= 1'b0;
      found     <= 1'b0;
    end else if (state == S_SCAN) begin
      step      <= step + 1'b1;
      dup       <= (kind == KIND_INSERT) && dup_seen;
      have_free <= free_seen;
      found     <= found || (kind == KIND_LOOKUP && hit_exact);
      if (kind == KIND_DELETE && hit_masked) begin
        removed <= removed + 1'b1;
      end
    end else if (state == S_CLEAR) begin
      removed <= count;
    end
    if (load_out) begin
      m_tdata <= {7'b0, CNT_OUT_W'(count), CNT_OUT_W'(removed), found, status};
    end
  end

  `TKTWD_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, count <= CNT_W'(TABLE_DEPTH),
      "occupancy above table depth")
  `TKTWD_ASSERT_NEXT(a_lookup_keeps_count, clk, rst,
      state == S_SCAN && kind == KIND_LOOKUP, $stable(count),
      "lookup changed occupancy")
  `TKTWD_ASSERT_IMP(a_place_only_new_insert, clk, rst, state == S_PLACE,
      kind == KIND_INSERT && !dup && have_free, "placement without free slot")
  `TKTWD_ASSERT_NEXT(a_accept_leaves_idle, clk, rst, accept, state != S_IDLE,
      "request accepted but sequencer stayed idle")

endmodule

/* hdl/triple_key_table_wildcard_delete_top.sv */
// Top level of the triple-key table: ring of slot cells plus sequencer.
//
// Requests enter on the s_ channel: s_tuser carries the operation (insert,
// delete matching, lookup, clear) and s_tdata the three keys and the three
// wildcard flags used by delete. Each request gives one result on the m_
// channel: status, found, removed count and occupancy after the request.
// The table is a ring of TABLE_DEPTH cells; a request other than clear
// rotates the ring one slot per cycle, every slot passing the head where it
// is compared, dropped or filled. Delete and lookup walk the ring once;
// insert walks it once and, for a new triple with a free slot seen, rotates
// on to the first free slot to fill it; clear empties every cell at once.
// A new request is accepted once the previous result sits in the
// output register, even if the receiver has not taken it yet. If the
// receiver stalls, the sequencer holds the next result until the register
// frees up. Reset empties the table and the output register at once.
module triple_key_table_wildcard_delete_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // [15:0] first_key, [31:16] second_key, [47:32] third_key,
  // [48] first_any, [49] second_any, [50] third_any, [55:51] zero
  input  logic [tktwd_pkg::IN_TDATA_W-1:0]   s_tdata,
  // [1:0] kind
  input  logic [1:0]                         s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [1:0] status, [2] found, [13:3] removed_count, [24:14] occupancy,
  // [31:25] zero
  output logic [tktwd_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import tktwd_pkg::*;

  entry_t    ring [TABLE_DEPTH];
  entry_t    head;
  ring_ctl_t ctl;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      tktwd_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl),
        .prev (head),
        .cur  (ring[i])
      );
    end else begin : g_rest
      tktwd_cell u_cell (
        .clk  (clk),
        .rst  (rst),
        .ctl  (ctl),
        .prev (ring[i-1]),
        .cur  (ring[i])
      );
    end
  end

  tktwd_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .tail     (ring[TABLE_DEPTH-1]),
    .head     (head),
    .ctl      (ctl)
  );

endmodule
